>>> rtl/core/c3s_pkg.sv
// Shared constants for the 3x3 strided convolution block.
// Holds field widths, configuration register codes and default parameter values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package c3s_pkg;

  // default geometry and coefficient size
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int COEF_BITS_DEF = 8;

  // fixed field widths
  localparam int PIX_W    = 8;
  localparam int ROW_W    = 12;
  localparam int HCFG_W   = 12;
  localparam int WCFG_W   = 11;
  localparam int STRIDE_W = 8;

  // largest pixel value, used by the clamp
  localparam int PIX_MAX = 255;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KROW0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KROW1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KROW2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd5;

  // reset values of the size registers
  localparam logic [HCFG_W-1:0]   HEIGHT_RST = 12'd480;
  localparam logic [WCFG_W-1:0]   WIDTH_RST  = 11'd640;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 8'd1;

endpackage : c3s_pkg

`default_nettype wire

>>> rtl/core/conv3x3_strided_clamp_unit.sv
// 3x3 strided convolution with clamp over a raster pixel stream.
// Path: a pixel's result passes the stage one registers, then mac stages a, b and c and the output register.
// Throughput: one pixel per cycle while in_stall is low, set by the single line store RAM read-modify-write.
// Reset: clears position counters, pipeline valid bits and config to defaults;
// the line store RAM and window are not cleared and hold data once written.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_strided_clamp_unit
  import c3s_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        cfg_valid,
  output logic                                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]                        cfg_index,
  input  wire logic [((3*COEF_BITS > HCFG_W) ? 3*COEF_BITS : HCFG_W)-1:0] cfg_data,
  input  wire logic                                        in_valid,
  output logic                                             in_stall,
  input  wire logic [PIX_W-1:0]                            pixel,
  output logic                                             out_valid,
  input  wire logic                                        out_stall,
  output logic [PIX_W-1:0]                                 value,
  output logic [ROW_W-1:0]                                 center_row,
  output logic [$clog2(MAX_WIDTH)-1:0]                     center_col
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int KROW_W = 3 * COEF_BITS;
  localparam int LINE_W = 2 * PIX_W;

  localparam logic [COEF_BITS-1:0] C_ZERO = '0;
  localparam logic [COEF_BITS-1:0] C_ONE  = COEF_BITS'(1);
  localparam logic [COEF_BITS-1:0] C_NEG1 = '1;
  localparam logic [COEF_BITS-1:0] C_FIVE = COEF_BITS'(5);
  localparam logic [KROW_W-1:0] KROW0_RST = {C_ZERO, C_ONE, C_ZERO};
  localparam logic [KROW_W-1:0] KROW1_RST = {C_NEG1, C_FIVE, C_NEG1};
  localparam logic [KROW_W-1:0] KROW2_RST = {C_ZERO, C_NEG1, C_ZERO};

  // configuration registers
  logic [KROW_W-1:0]   krow0;
  logic [KROW_W-1:0]   krow1;
  logic [KROW_W-1:0]   krow2;
  logic [HCFG_W-1:0]   height;
  logic [WCFG_W-1:0]   width;
  logic [STRIDE_W-1:0] stride;

  // accept stage and position info
  logic                in_acc;
  logic                seq_emit;
  logic [COL_W-1:0]    seq_col;
  logic [ROW_W-1:0]    seq_row_c;
  logic [COL_W-1:0]    seq_col_c;

  // line store stage
  logic                v1;
  logic                emit1;
  logic [PIX_W-1:0]    px1;
  logic [COL_W-1:0]    addr1;
  logic [ROW_W-1:0]    crow1;
  logic [COL_W-1:0]    ccol1;
  logic                adv1;
  logic                mac_ready;
  logic                wr_en;
  logic [LINE_W-1:0]   wr_data;
  logic [LINE_W-1:0]   ram_q;
  logic [LINE_W-1:0]   line_word;
  logic                fwd_hit;
  logic [LINE_W-1:0]   fwd_word;
  logic [PIX_W-1:0]    top;
  logic [PIX_W-1:0]    mid;

  logic [8:0][PIX_W-1:0] window;
  logic [8:0][PIX_W-1:0] window_next;

  assign cfg_ready = 1'b1;

  // config write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      krow0  <= KROW0_RST;
      krow1  <= KROW1_RST;
      krow2  <= KROW2_RST;
      height <= HEIGHT_RST;
      width  <= WIDTH_RST;
      stride <= STRIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KROW0:  krow0  <= cfg_data[KROW_W-1:0];
        REG_KROW1:  krow1  <= cfg_data[KROW_W-1:0];
        REG_KROW2:  krow2  <= cfg_data[KROW_W-1:0];
        REG_HEIGHT: height <= cfg_data[HCFG_W-1:0];
        REG_WIDTH:  width  <= cfg_data[WCFG_W-1:0];
        REG_STRIDE: stride <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage one leaves when the mac can take it, or at once for a non-result pixel
  assign adv1     = v1 && (!emit1 || mac_ready);
  assign in_stall = v1 && !adv1;
  assign in_acc   = in_valid && !in_stall;

  c3s_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .adv        (in_acc),
    .cfg_width  (width),
    .cfg_height (height),
    .cfg_stride (stride),
    .emit       (seq_emit),
    .col        (seq_col),
    .center_row (seq_row_c),
    .center_col (seq_col_c)
  );

  // line store: upper byte is the older row, lower byte the newer row
  assign wr_en   = adv1;
  assign wr_data = {mid, px1};

  c3s_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr1),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (seq_col),
    .rd_data (ram_q)
  );

  // forward the write when the next read hits the same column in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_acc) begin
      fwd_hit <= wr_en && (seq_col == addr1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_word <= wr_data;
    end
  end

  assign line_word = fwd_hit ? fwd_word : ram_q;
  assign top       = line_word[LINE_W-1:PIX_W];
  assign mid       = line_word[PIX_W-1:0];

  // stage one registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_acc) begin
      v1 <= 1'b1;
    end else if (adv1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px1   <= pixel;
      emit1 <= seq_emit;
      addr1 <= seq_col;
      crow1 <= seq_row_c;
      ccol1 <= seq_col_c;
    end
  end

  // window shifts left by one column per pixel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      window_next[3*i]   = window[3*i+1];
      window_next[3*i+1] = window[3*i+2];
    end
    window_next[2] = top;
    window_next[5] = mid;
    window_next[8] = px1;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      window <= window_next;
    end
  end

  c3s_mac #(
    .COEF_BITS (COEF_BITS),
    .COL_W     (COL_W)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .win_valid  (v1 && emit1),
    .win_ready  (mac_ready),
    .win        (window_next),
    .win_row    (crow1),
    .win_col    (ccol1),
    .krow0      (krow0),
    .krow1      (krow1),
    .krow2      (krow2),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .center_row (center_row),
    .center_col (center_col)
  );

  // an accepted pixel always occupies stage one on the next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> v1)
    else $error("accepted pixel missing from stage one");

  // a held stage-one word keeps its column address
  a_hold_addr: assert property (@(posedge clk) disable iff (rst)
    (v1 && !adv1) |=> (v1 && $stable(addr1)))
    else $error("stalled stage one lost its column");

  // same-column read during write must be served by the forward path
  a_fwd_same_col: assert property (@(posedge clk) disable iff (rst)
    (in_acc && wr_en && (seq_col == addr1)) |=> fwd_hit)
    else $error("missed line store forward");

  // result words only come from interior centers
  a_interior_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((center_row != '0) && (center_col != '0)))
    else $error("result word at a border position");

endmodule : conv3x3_strided_clamp_unit

`default_nettype wire

>>> rtl/core/c3s_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Read returns the old contents when read and write hit the same address.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module c3s_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : c3s_ram

`default_nettype wire

>>> rtl/core/c3s_seq.sv
// Raster position and stride phase tracking for the convolution block.
// Flags which accepted pixels complete a window on the stride grid.
// Depends on c3s_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c3s_seq
  import c3s_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic [WCFG_W-1:0]            cfg_width,
  input  wire logic [HCFG_W-1:0]            cfg_height,
  input  wire logic [STRIDE_W-1:0]          cfg_stride,
  output logic                              emit,
  output logic [$clog2(MAX_WIDTH)-1:0]      col,
  output logic [ROW_W-1:0]                  center_row,
  output logic [$clog2(MAX_WIDTH)-1:0]      center_col
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
  localparam int WEFF_W = (WMAX_W > WCFG_W) ? WMAX_W : WCFG_W;

  logic [ROW_W-1:0]    row;
  logic [STRIDE_W-1:0] row_phase;
  logic [STRIDE_W-1:0] col_phase;

  logic [COL_W-1:0]    col_next;
  logic [ROW_W-1:0]    row_next;
  logic [STRIDE_W-1:0] row_phase_next;
  logic [STRIDE_W-1:0] col_phase_next;

  logic [WEFF_W-1:0]   w_cfg_ext;
  logic [WEFF_W-1:0]   w_eff;
  logic [HCFG_W-1:0]   h_eff;
  logic [STRIDE_W-1:0] s_eff;
  logic [WEFF_W-1:0]   col_ext;
  logic [WEFF_W-1:0]   col_inc;
  logic [ROW_W:0]      row_inc;
  logic                interior;
  logic                row_end;
  logic                frame_end;
  logic [STRIDE_W-1:0] col_phase_adv;
  logic [STRIDE_W-1:0] row_phase_adv;

  // effective frame size and stride
  always_comb begin
    w_cfg_ext = WEFF_W'(cfg_width);
    if (w_cfg_ext > WEFF_W'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else if (w_cfg_ext == '0) begin
      w_eff = WEFF_W'(1);
    end else begin
      w_eff = w_cfg_ext;
    end
    h_eff = (cfg_height == '0) ? HCFG_W'(1) : cfg_height;
    s_eff = (cfg_stride == '0) ? STRIDE_W'(1) : cfg_stride;
  end

  // phase advance wraps at the stride
  always_comb begin
    if ((STRIDE_W + 1)'(col_phase) + (STRIDE_W + 1)'(1) >= (STRIDE_W + 1)'(s_eff)) begin
      col_phase_adv = '0;
    end else begin
      col_phase_adv = col_phase + STRIDE_W'(1);
    end
    if ((STRIDE_W + 1)'(row_phase) + (STRIDE_W + 1)'(1) >= (STRIDE_W + 1)'(s_eff)) begin
      row_phase_adv = '0;
    end else begin
      row_phase_adv = row_phase + STRIDE_W'(1);
    end
  end

  // window position test and emit decision
  always_comb begin
    col_ext   = WEFF_W'(col);
    col_inc   = col_ext + WEFF_W'(1);
    row_inc   = (ROW_W + 1)'(row) + (ROW_W + 1)'(1);
    interior  = (row >= ROW_W'(2)) && (col_ext >= WEFF_W'(2)) &&
                (row < h_eff) && (col_ext < w_eff);
    emit      = interior && (row_phase == '0) && (col_phase == '0);
    row_end   = (col_inc >= w_eff);
    frame_end = (row_inc >= (ROW_W + 1)'(h_eff));
    center_row = row - ROW_W'(1);
    center_col = col - COL_W'(1);
  end

  // next position
  always_comb begin
    col_next       = col + COL_W'(1);
    row_next       = row;
    row_phase_next = row_phase;
    col_phase_next = interior ? col_phase_adv : col_phase;
    if (row_end) begin
      col_next       = '0;
      col_phase_next = '0;
      if (frame_end) begin
        row_next       = '0;
        row_phase_next = '0;
      end else begin
        if (row >= ROW_W'(2)) begin
          row_phase_next = row_phase_adv;
        end
        row_next = row_inc[ROW_W-1:0];
      end
    end
  end

  // position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      row_phase <= '0;
      col_phase <= '0;
    end else if (adv) begin
      col       <= col_next;
      row       <= row_next;
      row_phase <= row_phase_next;
      col_phase <= col_phase_next;
    end
  end

endmodule : c3s_seq

`default_nettype wire

>>> rtl/core/c3s_mac.sv
// Multiply-accumulate pipeline for one 3x3 window, with clamp to 0..255.
// Three registered stages feed the output register; bubbles collapse on stall.
// Depends on c3s_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c3s_mac
  import c3s_pkg::*;
#(
  parameter int COEF_BITS = COEF_BITS_DEF,
  parameter int COL_W     = $clog2(MAX_WIDTH_DEF)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     win_valid,
  output logic                          win_ready,
  input  wire logic [8:0][PIX_W-1:0]    win,
  input  wire logic [ROW_W-1:0]         win_row,
  input  wire logic [COL_W-1:0]         win_col,
  input  wire logic [3*COEF_BITS-1:0]   krow0,
  input  wire logic [3*COEF_BITS-1:0]   krow1,
  input  wire logic [3*COEF_BITS-1:0]   krow2,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [PIX_W-1:0]              value,
  output logic [ROW_W-1:0]              center_row,
  output logic [COL_W-1:0]              center_col
);

  localparam int PROD_W = PIX_W + COEF_BITS + 1;
  localparam int RSUM_W = PROD_W + 2;
  localparam int TOT_W  = PROD_W + 4;

  // stage a: window copy
  logic                      va;
  logic [8:0][PIX_W-1:0]     win_a;
  logic [ROW_W-1:0]          row_a;
  logic [COL_W-1:0]          col_a;
  // stage b: products
  logic                      vb;
  logic signed [PROD_W-1:0]  prod_b [9];
  logic [ROW_W-1:0]          row_b;
  logic [COL_W-1:0]          col_b;
  // stage c: row sums
  logic                      vc;
  logic signed [RSUM_W-1:0]  rsum_c [3];
  logic [ROW_W-1:0]          row_c;
  logic [COL_W-1:0]          col_c;

  logic                      rdy_o;
  logic                      rdy_c;
  logic                      rdy_b;
  logic                      rdy_a;
  logic signed [PROD_W-1:0]  prod [9];
  logic signed [RSUM_W-1:0]  rsum [3];
  logic signed [TOT_W-1:0]   total;
  logic [PIX_W-1:0]          clamped;
  logic [3*COEF_BITS-1:0]    krow_sel [3];

  // per-stage ready, a stage moves when the next is empty or moving
  assign rdy_o     = !out_valid || !out_stall;
  assign rdy_c     = !vc || rdy_o;
  assign rdy_b     = !vb || rdy_c;
  assign rdy_a     = !va || rdy_b;
  assign win_ready = rdy_a;

  assign krow_sel[0] = krow0;
  assign krow_sel[1] = krow1;
  assign krow_sel[2] = krow2;

  // nine pixel by coefficient products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[3*i+j] = PROD_W'($signed({1'b0, win_a[3*i+j]}) *
                              $signed(krow_sel[i][COEF_BITS*j +: COEF_BITS]));
      end
    end
  end

  // row sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = RSUM_W'(prod_b[3*i]) + RSUM_W'(prod_b[3*i+1]) + RSUM_W'(prod_b[3*i+2]);
    end
  end

  // final sum and clamp
  always_comb begin
    total = TOT_W'(rsum_c[0]) + TOT_W'(rsum_c[1]) + TOT_W'(rsum_c[2]);
    if (total < 0) begin
      clamped = '0;
    end else if (total > TOT_W'(PIX_MAX)) begin
      clamped = PIX_W'(PIX_MAX);
    end else begin
      clamped = total[PIX_W-1:0];
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) va <= win_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_o) out_valid <= vc;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (rdy_a && win_valid) begin
      win_a <= win;
      row_a <= win_row;
      col_a <= win_col;
    end
    if (rdy_b && va) begin
      prod_b <= prod;
      row_b  <= row_a;
      col_b  <= col_a;
    end
    if (rdy_c && vb) begin
      rsum_c <= rsum;
      row_c  <= row_b;
      col_c  <= col_b;
    end
    if (rdy_o && vc) begin
      value      <= clamped;
      center_row <= row_c;
      center_col <= col_c;
    end
  end

endmodule : c3s_mac

`default_nettype wire
